FILE: rtl/core/min_path_grid_wrap_dp_top_macros.svh
// assertion macros used by the checker file
// no dependencies
`ifndef MIN_PATH_GRID_WRAP_DP_TOP_MACROS_SVH
`define MIN_PATH_GRID_WRAP_DP_TOP_MACROS_SVH
// implication checked on every rising clock edge outside reset
`define MPG_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error(msg);
// next-cycle implication
`define MPG_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error(msg);
`endif

FILE: rtl/core/mpg_pkg.sv
// shared types and constants for the min path grid block
// no dependencies
`default_nettype none
package mpg_pkg;
  localparam int unsigned WeightW = 16;
  localparam int unsigned CostW   = 22;
  localparam int unsigned RowW    = 4;
  localparam int unsigned ColW    = 6;
  localparam int unsigned NRowCfgW = 5;
  localparam int unsigned NColCfgW = 7;
  localparam logic [1:0] RegNumRows = 2'd0;
  localparam logic [1:0] RegNumCols = 2'd1;
  typedef logic signed [CostW-1:0] cost_t;
  typedef logic [RowW-1:0] row_t;
  typedef logic [ColW-1:0] col_t;
  // memory request from the sequencer
  typedef struct packed {
    logic       cwe;
    logic       pwe;
    logic [9:0] waddr;
    cost_t      cwdata;
    row_t       pwdata;
    logic [9:0] craddr;
    logic [9:0] praddr0;
    logic [9:0] praddr1;
  } mem_req_t;
  typedef struct packed {
    cost_t crdata;
    row_t  prdata0;
    row_t  prdata1;
  } mem_rsp_t;
endpackage
`default_nettype wire

FILE: rtl/core/min_path_grid_wrap_dp_top.sv
// Minimum-weight left-to-right path over a grid with row wraparound. Cells are
// taken one per cycle in row-major order; after the last cell the block stalls
// its input while a sequencer runs the column pass out of the cost and
// predecessor memories: each candidate is addressed, read, compared, then the
// next is taken; each cell ends in a write back; a tie-break walk reads
// predecessors back column by column, then decides. Final selection repeats
// the candidate steps per row, then the path is traced. One result word per
// column is emitted, one per cycle without stalls. Depends on mpg_pkg, mpg_seq.
`default_nettype none
module min_path_grid_wrap_dp_top #(
  parameter int unsigned MAX_ROWS = 16,
  parameter int unsigned MAX_COLS = 64
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_psel,
  input  wire logic        cfg_penable,
  input  wire logic        cfg_pwrite,
  input  wire logic [2:0]  cfg_paddr,
  input  wire logic [31:0] cfg_pwdata,
  output logic [31:0]      cfg_prdata,
  output logic             cfg_pready,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic signed [15:0] in_cell_weight,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [3:0]       out_path_row,
  output logic [5:0]       out_column_index,
  output logic signed [21:0] out_total_cost,
  output logic             out_last_result
);
  logic [4:0] num_rows_r;
  logic [6:0] num_cols_r;
  logic wr, hit;

  assign cfg_pready = 1'b1;
  assign wr = cfg_psel && cfg_penable && cfg_pwrite;
  assign hit = wr && (cfg_paddr[2] == mpg_pkg::RegNumRows[0] ||
                      cfg_paddr[2] == mpg_pkg::RegNumCols[0]) && cfg_paddr[1:0] == 2'b00;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      num_rows_r <= 5'd16;
      num_cols_r <= 7'd64;
    end else if (hit) begin
      if (cfg_paddr[2] == mpg_pkg::RegNumRows[0]) begin
        num_rows_r <= cfg_pwdata[4:0];
      end else begin
        num_cols_r <= cfg_pwdata[6:0];
      end
    end
  end

  always_comb begin
    cfg_prdata = '0;
    if (cfg_paddr == 3'd0) begin
      cfg_prdata = {27'd0, num_rows_r};
    end else if (cfg_paddr == 3'd4) begin
      cfg_prdata = {25'd0, num_cols_r};
    end
  end

  mpg_seq #(.MAX_ROWS(MAX_ROWS), .MAX_COLS(MAX_COLS)) u_seq (
    .clk(clk), .rst_n(rst_n), .num_rows(num_rows_r), .num_cols(num_cols_r),
    .restart(hit), .in_valid(in_valid), .in_stall(in_stall),
    .in_cell_weight(in_cell_weight), .out_valid(out_valid), .out_stall(out_stall),
    .out_path_row(out_path_row), .out_column_index(out_column_index),
    .out_total_cost(out_total_cost), .out_last_result(out_last_result)
  );
endmodule
`default_nettype wire

FILE: rtl/core/mpg_store.sv
// cost memory (one write, one read port) and predecessor memory
// (one write, two read ports), registered reads; uses mpg_pkg
`default_nettype none
module mpg_store #(
  parameter int unsigned AW = 10
) (
  input  wire logic             clk,
  input  wire mpg_pkg::mem_req_t req,
  output mpg_pkg::mem_rsp_t      rsp
);
  mpg_pkg::cost_t cost_mem [2**AW];
  mpg_pkg::row_t  pa_mem   [2**AW];
  mpg_pkg::row_t  pb_mem   [2**AW];
  mpg_pkg::mem_rsp_t rsp_r;

  // predecessor copies give the walk two read ports
  always_ff @(posedge clk) begin
    if (req.cwe) begin
      cost_mem[req.waddr[AW-1:0]] <= req.cwdata;
    end
    if (req.pwe) begin
      pa_mem[req.waddr[AW-1:0]] <= req.pwdata;
      pb_mem[req.waddr[AW-1:0]] <= req.pwdata;
    end
    rsp_r.crdata  <= cost_mem[req.craddr[AW-1:0]];
    rsp_r.prdata0 <= pa_mem[req.praddr0[AW-1:0]];
    rsp_r.prdata1 <= pb_mem[req.praddr1[AW-1:0]];
  end
  assign rsp = rsp_r;
endmodule
`default_nettype wire

FILE: rtl/core/mpg_seq.sv
// sequencer: loading, column dp pass with tie-break walk-backs, final
// selection, path trace and result emission; uses mpg_pkg and mpg_store
`default_nettype none
module mpg_seq #(
  parameter int unsigned MAX_ROWS = 16,
  parameter int unsigned MAX_COLS = 64
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic [mpg_pkg::NRowCfgW-1:0]    num_rows,
  input  wire logic [mpg_pkg::NColCfgW-1:0]    num_cols,
  input  wire logic                            restart,
  input  wire logic                            in_valid,
  output logic                                 in_stall,
  input  wire logic signed [mpg_pkg::WeightW-1:0] in_cell_weight,
  output logic                                 out_valid,
  input  wire logic                            out_stall,
  output logic [mpg_pkg::RowW-1:0]             out_path_row,
  output logic [mpg_pkg::ColW-1:0]             out_column_index,
  output logic signed [mpg_pkg::CostW-1:0]     out_total_cost,
  output logic                                 out_last_result
);
  localparam int unsigned MCW = mpg_pkg::ColW;
  localparam logic [9:0] ColsL = 10'(MAX_COLS);

  typedef enum logic [3:0] {
    S_LOAD, S_CAND, S_RDC, S_CMPC, S_WALK, S_WWAIT, S_WCMP, S_ACC_RD,
    S_ACC_WR, S_TRACE_RD, S_TRACE, S_EMIT
  } state_t;

  state_t state_r;
  mpg_pkg::mem_req_t req;
  mpg_pkg::mem_rsp_t rsp;

  mpg_pkg::row_t nr_m1, ld_row_r, i_r, best_r, cand_r, wa_r, wb_r, tr_r;
  mpg_pkg::col_t nc_m1, ld_col_r, j_r, wc_r;
  logic [1:0] k_r;           // candidate number: 0 up, 1 same, 2 down
  logic final_r;             // last-column selection rather than dp
  logic wd_r;                // sign of walk compare: candidate smaller
  logic wdiff_r;
  mpg_pkg::cost_t bcost_r, ccost_r, tot_r;
  mpg_pkg::row_t path_r [MAX_COLS];
  mpg_pkg::row_t pr_r;
  mpg_pkg::col_t oc_r;

  mpg_pkg::row_t up_row, dn_row, cand_row;
  logic [4:0] nr_e;
  logic [7:0] nc_e;

  mpg_store #(.AW(10)) u_store (.clk(clk), .req(req), .rsp(rsp));

  always_comb begin
    nr_e = (num_rows == '0) ? 5'd1 :
           ({27'd0, num_rows} > 32'(MAX_ROWS)) ? 5'(MAX_ROWS) : num_rows;
    nc_e = (num_cols == '0) ? 8'd1 :
           ({25'd0, num_cols} > 32'(MAX_COLS)) ? 8'(MAX_COLS) : {1'b0, num_cols};
    nr_m1 = mpg_pkg::RowW'(nr_e - 5'd1);
    nc_m1 = MCW'(nc_e - 8'd1);
  end

  function automatic logic [9:0] addr(input mpg_pkg::row_t r, input mpg_pkg::col_t c);
    addr = 10'(r) * ColsL + 10'(c);
  endfunction

  always_comb begin
    up_row = (i_r == '0) ? nr_m1 : i_r - 4'd1;
    dn_row = (i_r == nr_m1) ? '0 : i_r + 4'd1;
    cand_row = final_r ? i_r : (k_r == 2'd0) ? up_row : (k_r == 2'd1) ? i_r : dn_row;
  end

  assign in_stall  = (state_r != S_LOAD);
  assign out_valid = (state_r == S_EMIT);
  assign out_path_row = pr_r;
  assign out_column_index = oc_r;
  assign out_total_cost = tot_r;
  assign out_last_result = (oc_r == nc_m1);

  always_comb begin
    req = '0;
    case (state_r)
      S_LOAD: begin
        req.cwe = in_valid;
        req.waddr = addr(ld_row_r, ld_col_r);
        req.cwdata = mpg_pkg::CostW'(in_cell_weight);
      end
      // address held through S_CAND and S_RDC so the compare sees the candidate cost
      S_CAND, S_RDC: begin
        req.craddr = final_r ? addr(cand_row, nc_m1) : addr(cand_row, j_r - 6'd1);
      end
      S_WALK: begin
        req.praddr0 = addr(wa_r, wc_r);
        req.praddr1 = addr(wb_r, wc_r);
      end
      S_ACC_RD: req.craddr = addr(i_r, j_r);
      S_ACC_WR: begin
        // cell weight read back in the previous state
        req.cwe = 1'b1;
        req.pwe = 1'b1;
        req.waddr = addr(i_r, j_r);
        req.cwdata = rsp.crdata + bcost_r;
        req.pwdata = best_r;
      end
      S_TRACE_RD: req.praddr0 = addr(tr_r, j_r);
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_LOAD;
      ld_row_r <= '0;
      ld_col_r <= '0;
      oc_r <= '0;
    end else begin
      case (state_r)
        S_LOAD: begin
          if (restart) begin
            ld_row_r <= '0;
            ld_col_r <= '0;
          end else if (in_valid) begin
            if (ld_col_r < nc_m1) begin
              ld_col_r <= ld_col_r + 6'd1;
            end else begin
              ld_col_r <= '0;
              if (ld_row_r < nr_m1) begin
                ld_row_r <= ld_row_r + 4'd1;
              end else begin
                ld_row_r <= '0;
                i_r <= '0;
                k_r <= '0;
                j_r <= 6'd1;
                final_r <= (nc_m1 == '0);
                state_r <= S_CAND;
              end
            end
          end
        end
        S_CAND: state_r <= S_RDC;
        S_RDC: state_r <= S_CMPC;
        S_CMPC: begin
          ccost_r <= rsp.crdata;
          cand_r <= cand_row;
          if ((final_r && i_r == '0) || (!final_r && k_r == 2'd0)) begin
            best_r <= cand_row;
            bcost_r <= rsp.crdata;
            state_r <= S_ACC_RD;
          end else if ($signed(rsp.crdata) < $signed(bcost_r)) begin
            best_r <= cand_row;
            bcost_r <= rsp.crdata;
            state_r <= S_ACC_RD;
          end else if (rsp.crdata == bcost_r) begin
            wa_r <= cand_row;
            wb_r <= best_r;
            wc_r <= final_r ? nc_m1 : j_r - 6'd1;
            wd_r <= cand_row < best_r;
            wdiff_r <= cand_row != best_r;
            state_r <= (final_r ? nc_m1 : j_r - 6'd1) == '0 ? S_WCMP : S_WALK;
          end else begin
            state_r <= S_ACC_RD;
          end
        end
        S_WALK: state_r <= S_WWAIT;
        S_WWAIT: begin
          // earliest differing column decides
          wa_r <= rsp.prdata0;
          wb_r <= rsp.prdata1;
          if (rsp.prdata0 != rsp.prdata1) begin
            wd_r <= rsp.prdata0 < rsp.prdata1;
            wdiff_r <= 1'b1;
          end
          wc_r <= wc_r - 6'd1;
          state_r <= (wc_r == 6'd1) ? S_WCMP : S_WALK;
        end
        S_WCMP: begin
          if (wdiff_r && wd_r) begin
            best_r <= cand_r;
            bcost_r <= ccost_r;
          end
          state_r <= S_ACC_RD;
        end
        S_ACC_RD: begin
          // also the branch point after each candidate
          if (final_r) begin
            if (i_r == nr_m1) begin
              tot_r <= bcost_r;
              tr_r <= best_r;
              j_r <= nc_m1;
              state_r <= S_TRACE_RD;
            end else begin
              i_r <= i_r + 4'd1;
              state_r <= S_CAND;
            end
          end else if (k_r != 2'd2) begin
            k_r <= k_r + 2'd1;
            state_r <= S_CAND;
          end else begin
            state_r <= S_ACC_WR;
          end
        end
        S_ACC_WR: begin
          k_r <= '0;
          if (i_r == nr_m1) begin
            i_r <= '0;
            if (j_r == nc_m1) begin
              final_r <= 1'b1;
            end else begin
              j_r <= j_r + 6'd1;
            end
          end else begin
            i_r <= i_r + 4'd1;
          end
          state_r <= S_CAND;
        end
        S_TRACE_RD: begin
          path_r[j_r] <= tr_r;
          if (j_r == '0) begin
            pr_r <= tr_r;
            state_r <= S_EMIT;
          end else begin
            state_r <= S_TRACE;
          end
        end
        S_TRACE: begin
          tr_r <= rsp.prdata0;
          j_r <= j_r - 6'd1;
          state_r <= S_TRACE_RD;
        end
        S_EMIT: begin
          if (!out_stall) begin
            if (oc_r == nc_m1) begin
              oc_r <= '0;
              state_r <= S_LOAD;
            end else begin
              // path row of the next column is fetched into the output register
              pr_r <= path_r[oc_r + 6'd1];
              oc_r <= oc_r + 6'd1;
            end
          end
        end
        default: state_r <= S_LOAD;
      endcase
    end
  end
endmodule
`default_nettype wire

FILE: rtl/core/mpg_checker.sv
// port-level checker for the min path grid block, bound to the top level
// uses min_path_grid_wrap_dp_top_macros.svh
`default_nettype none
`include "min_path_grid_wrap_dp_top_macros.svh"
module mpg_checker (
  input wire logic       clk,
  input wire logic       rst_n,
  input wire logic       in_stall,
  input wire logic       out_valid,
  input wire logic       out_stall,
  input wire logic [5:0] out_column_index,
  input wire logic       out_last_result
);
  `MPG_ASSERT_IMP(a_no_in_while_out, clk, rst_n, out_valid, in_stall, "input open during emit")
  `MPG_ASSERT_NXT(a_col_step, clk, rst_n, out_valid && !out_stall && !out_last_result, out_valid && out_column_index == $past(out_column_index) + 6'd1, "column skipped")
  `MPG_ASSERT_NXT(a_last_ends, clk, rst_n, out_valid && !out_stall && out_last_result, !out_valid, "emit after last")
endmodule
bind min_path_grid_wrap_dp_top mpg_checker u_chk (
  .clk(clk), .rst_n(rst_n), .in_stall(in_stall), .out_valid(out_valid),
  .out_stall(out_stall), .out_column_index(out_column_index),
  .out_last_result(out_last_result)
);
`default_nettype wire

FILE: dv/tb.sv
// self-checking bench for min_path_grid_wrap_dp_top: grids go in over the valid/stall
// channel, path words are checked against a behavioral predictor of the path dp
// depends on mpg_pkg and the min_path_grid_wrap_dp_top rtl
`timescale 1ns / 100ps
module tb;
  localparam int LIMIT = 2000000;
  localparam int ROWS_MAX = 16;
  localparam int COLS_MAX = 64;

  typedef struct {
    mpg_pkg::row_t  row;
    mpg_pkg::col_t  col;
    mpg_pkg::cost_t cost;
    logic  last;
  } path_word_t;

  typedef struct {
    bit   is_cfg;
    logic [2:0] addr;
    int   val;
    bit   typed;
    int   cost;
  } dir_row_t;

  logic clk = 1'b0;
  logic rst_n;
  logic cfg_psel, cfg_penable, cfg_pwrite;
  logic [2:0] cfg_paddr;
  logic [31:0] cfg_pwdata;
  logic [31:0] cfg_prdata;
  logic cfg_pready;
  logic in_valid, in_stall;
  logic signed [15:0] in_cell_weight;
  logic out_valid, out_stall;
  logic [3:0] out_path_row;
  logic [5:0] out_column_index;
  logic signed [21:0] out_total_cost;
  logic out_last_result;

  min_path_grid_wrap_dp_top u_dut (
    .clk(clk), .rst_n(rst_n),
    .cfg_psel(cfg_psel), .cfg_penable(cfg_penable), .cfg_pwrite(cfg_pwrite),
    .cfg_paddr(cfg_paddr), .cfg_pwdata(cfg_pwdata), .cfg_prdata(cfg_prdata),
    .cfg_pready(cfg_pready),
    .in_valid(in_valid), .in_stall(in_stall), .in_cell_weight(in_cell_weight),
    .out_valid(out_valid), .out_stall(out_stall), .out_path_row(out_path_row),
    .out_column_index(out_column_index), .out_total_cost(out_total_cost),
    .out_last_result(out_last_result)
  );

  always #10 clk = ~clk;

  // predictor state
  int   grid_cost[ROWS_MAX*COLS_MAX];
  mpg_pkg::row_t grid_pred[ROWS_MAX*COLS_MAX];
  int   ld_row, ld_col;
  int   rows_reg, cols_reg;

  path_word_t path_words_q[$];
  bit   typed_q[$];
  int   typed_cost_q[$];
  dir_row_t dir_rows[$];

  int in_idle_pct, out_stall_pct;
  int hold_req, hold_left;
  int cycles, errors, words_seen, grids_done, items_sent;

  function automatic int cell_at(int r, int c);
    return r * COLS_MAX + c;
  endfunction

  // earliest differing column of the traced-back row sequences decides
  function automatic int seq_cmp(int a, int b, int col);
    int d;
    d = 0;
    while (1) begin
      if (a != b) d = (a < b) ? -1 : 1;
      if (col == 0) break;
      a = grid_pred[cell_at(a, col)];
      b = grid_pred[cell_at(b, col)];
      col--;
    end
    return d;
  endfunction

  function automatic bit is_better(int p, int q, int col);
    int cp, cq;
    cp = grid_cost[cell_at(p, col)];
    cq = grid_cost[cell_at(q, col)];
    if (cp < cq) return 1;
    if (cp == cq) return seq_cmp(p, q, col) < 0;
    return 0;
  endfunction

  function automatic int clamp_reg(int v, int mx);
    if (v == 0) return 1;
    return (v > mx) ? mx : v;
  endfunction

  task automatic absorb_weight(input logic signed [15:0] w);
    int nr, nc, i, j, best, up, dn, total;
    int path[COLS_MAX];
    path_word_t pw;
    nr = clamp_reg(rows_reg, ROWS_MAX);
    nc = clamp_reg(cols_reg, COLS_MAX);
    if (ld_row >= nr || ld_col >= nc) begin
      ld_row = 0;
      ld_col = 0;
    end
    grid_cost[cell_at(ld_row, ld_col)] = int'(w);
    if (ld_col + 1 < nc) begin
      ld_col++;
      return;
    end
    ld_col = 0;
    if (ld_row + 1 < nr) begin
      ld_row++;
      return;
    end
    ld_row = 0;
    for (j = 1; j < nc; j++) begin
      for (i = 0; i < nr; i++) begin
        up = (i == 0) ? nr - 1 : i - 1;
        dn = (i + 1 == nr) ? 0 : i + 1;
        best = up;
        if (is_better(i, best, j - 1)) best = i;
        if (is_better(dn, best, j - 1)) best = dn;
        grid_cost[cell_at(i, j)] += grid_cost[cell_at(best, j - 1)];
        grid_pred[cell_at(i, j)] = mpg_pkg::row_t'(best);
      end
    end
    best = 0;
    for (i = 1; i < nr; i++)
      if (is_better(i, best, nc - 1)) best = i;
    total = grid_cost[cell_at(best, nc - 1)];
    for (j = nc - 1; j >= 0; j--) begin
      path[j] = best;
      best = grid_pred[cell_at(best, j)];
    end
    for (j = 0; j < nc; j++) begin
      pw.row = mpg_pkg::row_t'(path[j]);
      pw.col = mpg_pkg::col_t'(j);
      pw.cost = mpg_pkg::cost_t'(total);
      pw.last = (j + 1 == nc);
      path_words_q.push_back(pw);
    end
    grids_done++;
  endtask

  // input acceptance, sampled mid-cycle so the edge order does not matter
  always @(negedge clk) begin
    path_word_t pw;
    if (rst_n && in_valid && !in_stall) begin
      absorb_weight(in_cell_weight);
      if (typed_q.pop_front()) begin
        // single-cell grid: cost is the weight itself
        pw.row = '0;
        pw.col = '0;
        pw.cost = mpg_pkg::cost_t'(typed_cost_q[0]);
        pw.last = 1'b1;
        void'(path_words_q.pop_back());
        path_words_q.push_back(pw);
      end
      void'(typed_cost_q.pop_front());
    end
  end

  // result checking
  always @(negedge clk) begin
    path_word_t ew;
    if (rst_n && out_valid && !out_stall) begin
      words_seen++;
      if (path_words_q.size() == 0) begin
        errors++;
        $display("%0t unexpected word row=%0d col=%0d cost=%0d last=%0d", $time,
                 out_path_row, out_column_index, out_total_cost, out_last_result);
      end else begin
        ew = path_words_q.pop_front();
        if (out_path_row !== ew.row) begin
          errors++;
          $display("%0t path_row exp %0d got %0d", $time, ew.row, out_path_row);
        end
        if (out_column_index !== ew.col) begin
          errors++;
          $display("%0t column_index exp %0d got %0d", $time, ew.col, out_column_index);
        end
        if (out_total_cost !== ew.cost) begin
          errors++;
          $display("%0t total_cost exp %0d got %0d", $time, ew.cost, out_total_cost);
        end
        if (out_last_result !== ew.last) begin
          errors++;
          $display("%0t last_result exp %0d got %0d", $time, ew.last, out_last_result);
        end
      end
    end
  end

  // receiver: random stall, or a long hold-off on request
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
      hold_left <= 0;
    end else if (hold_req != 0) begin
      hold_left <= hold_req;
      hold_req = 0;
      out_stall <= 1'b1;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(0, 99) < out_stall_pct);
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT) begin
      $display("min_path_grid_wrap_dp_top: mismatch");
      $finish;
    end
  end

  task automatic send_weight(input logic signed [15:0] w, input bit typed, input int tcost);
    bit hs;
    while ($urandom_range(0, 99) < in_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    typed_q.push_back(typed);
    typed_cost_q.push_back(tcost);
    in_valid <= 1'b1;
    in_cell_weight <= w;
    items_sent++;
    hs = 0;
    while (!hs) begin
      @(negedge clk);
      hs = !in_stall;
      @(posedge clk);
    end
  endtask

  task automatic write_reg(input logic [2:0] addr, input int val);
    in_valid <= 1'b0;
    @(posedge clk);
    while (path_words_q.size() != 0 || typed_q.size() != 0) @(posedge clk);
    // a partly loaded grid may still be settling
    repeat (200) @(posedge clk);
    cfg_psel <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b1;
    cfg_paddr <= addr;
    cfg_pwdata <= val;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    if (addr == 3'(mpg_pkg::RegNumRows) * 4) rows_reg = val & 32'h1f;
    else cols_reg = val & 32'h7f;
    ld_row = 0;
    ld_col = 0;
  endtask

  task automatic dir(input bit is_cfg, input logic [2:0] addr, input int val,
                     input bit typed, input int cost);
    dir_row_t r;
    r.is_cfg = is_cfg;
    r.addr = addr;
    r.val = val;
    r.typed = typed;
    r.cost = cost;
    dir_rows.push_back(r);
  endtask

  task automatic send_grid(input int nr, input int nc, input bit ties);
    int k;
    write_reg(3'(mpg_pkg::RegNumRows) * 4, nr);
    write_reg(3'(mpg_pkg::RegNumCols) * 4, nc);
    for (k = 0; k < clamp_reg(nr, ROWS_MAX) * clamp_reg(nc, COLS_MAX); k++)
      send_weight(ties ? 16'($signed($urandom_range(0, 3)) - 1) : 16'($urandom), 0, 0);
  endtask

  initial begin
    int k, ph, start;
    rst_n <= 1'b0;
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
    cfg_paddr <= '0;
    cfg_pwdata <= '0;
    in_valid <= 1'b0;
    in_cell_weight <= '0;
    rows_reg = ROWS_MAX;
    cols_reg = COLS_MAX;
    ld_row = 0;
    ld_col = 0;
    hold_req = 0;
    in_idle_pct = 0;
    out_stall_pct = 0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // zero register values count as one: 1x1 grids
    dir(1, 3'(mpg_pkg::RegNumRows) * 4, 0, 0, 0);
    dir(1, 3'(mpg_pkg::RegNumCols) * 4, 0, 0, 0);
    dir(0, 0, -32768, 1, -32768);
    dir(0, 0, 32767, 1, 32767);
    dir(0, 0, 0, 1, 0);
    dir(0, 0, -1, 1, -1);
    // partial load, then a register write restarts loading
    dir(1, 3'(mpg_pkg::RegNumRows) * 4, 3, 0, 0);
    dir(1, 3'(mpg_pkg::RegNumCols) * 4, 2, 0, 0);
    dir(0, 0, 100, 0, 0);
    dir(0, 0, -100, 0, 0);
    dir(0, 0, 5, 0, 0);
    dir(1, 3'(mpg_pkg::RegNumRows) * 4, 2, 0, 0);
    // equal weights: tie goes to the smallest row sequence
    for (k = 0; k < 4; k++) dir(0, 0, 7, 0, 0);
    // 3x3 where the best path wraps between first and last rows
    dir(1, 3'(mpg_pkg::RegNumCols) * 4, 3, 0, 0);
    dir(1, 3'(mpg_pkg::RegNumRows) * 4, 3, 0, 0);
    dir(0, 0, 1, 0, 0);
    dir(0, 0, 50, 0, 0);
    dir(0, 0, 1, 0, 0);
    dir(0, 0, 50, 0, 0);
    dir(0, 0, 50, 0, 0);
    dir(0, 0, 50, 0, 0);
    dir(0, 0, 50, 0, 0);
    dir(0, 0, 1, 0, 0);
    dir(0, 0, 50, 0, 0);
    foreach (dir_rows[i]) begin
      if (dir_rows[i].is_cfg) write_reg(dir_rows[i].addr, dir_rows[i].val);
      else send_weight(16'(dir_rows[i].val), dir_rows[i].typed, dir_rows[i].cost);
    end

    // extremes: clamped row count and full column count
    send_grid(31, 1, 0);
    send_grid(1, 127, 1);
    send_grid(2, 16, 1);

    for (ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin in_idle_pct = 0;  out_stall_pct = 0;  end
        1: begin in_idle_pct = 55; out_stall_pct = 0;  end
        2: begin in_idle_pct = 0;  out_stall_pct = 55; end
        default: begin in_idle_pct = 25; out_stall_pct = 25; end
      endcase
      start = items_sent;
      if (ph == 0) begin
        write_reg(3'(mpg_pkg::RegNumRows) * 4, 4);
        write_reg(3'(mpg_pkg::RegNumCols) * 4, 3);
        hold_req = 400;
        for (k = 0; k < 24; k++) send_weight(16'($urandom), 0, 0);
      end
      while (items_sent - start < 20)
        send_grid($urandom_range(0, 9) == 0 ? $urandom_range(0, 31) : $urandom_range(1, 5),
                  $urandom_range(0, 9) == 0 ? $urandom_range(0, 9) : $urandom_range(1, 6),
                  $urandom_range(0, 1));
    end

    in_valid <= 1'b0;
    while (path_words_q.size() != 0 || typed_q.size() != 0) @(posedge clk);
    repeat (300) @(posedge clk);
    $display("%0d cell words in, %0d grids solved, %0d path words checked", items_sent,
             grids_done, words_seen);
    $display("covered clamped sizes, ties, wraparound and restart on register write");
    if (errors == 0 && path_words_q.size() == 0) begin
      $display("min_path_grid_wrap_dp_top: match");
    end else begin
      $display("min_path_grid_wrap_dp_top: mismatch");
    end
    $finish;
  end
endmodule

FILE: min_path_grid_wrap_dp_top.f
+incdir+rtl/core
rtl/core/mpg_pkg.sv
rtl/core/mpg_store.sv
rtl/core/mpg_seq.sv
rtl/core/min_path_grid_wrap_dp_top.sv
rtl/core/mpg_checker.sv
dv/tb.sv
